// ----- src/assert_macros.svh -----
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define M4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define M4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/m4inv_pkg.sv -----
// Types, sequencer codes and address helpers for the 4x4 adjugate inverter.
package m4inv_pkg;

  typedef struct packed {
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic               last_element;
  } elem_t;

  typedef struct packed {
    logic [3:0]         result_index;
    logic signed [31:0] inverse_value;
    logic signed [31:0] determinant_value;
    logic               singular;
    logic               saturated;
    logic               last_result;
  } result_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_RDA, ST_RDB, ST_LDB, ST_MUL, ST_WB, ST_COF,
    ST_DFIN, ST_DRD, ST_DLD, ST_DIV, ST_EMIT
  } state_t;

  // Multiply-accumulate steps of one 3x3 minor, then the determinant step.
  localparam logic [3:0] STEP_FIRST = 4'd0;
  localparam logic [3:0] STEP_LAST  = 4'd8;
  localparam logic [3:0] STEP_DET   = 4'd9;

  typedef struct packed {
    logic       a_from_m;
    logic [1:0] ai;
    logic [1:0] aj;
    logic [1:0] bi;
    logic [1:0] bj;
    logic       to_acc;
    logic       clr;
    logic       sub;
  } mac_op_t;

  // Minor element (i,j) of the cofactor at row-major position k, as a store address.
  function automatic logic [3:0] minor_addr(input logic [3:0] k, input logic [1:0] i,
                                            input logic [1:0] j);
    logic [1:0] r;
    logic [1:0] c;
    r = (i >= k[3:2]) ? i + 2'd1 : i;
    c = (j >= k[1:0]) ? j + 2'd1 : j;
    return {r, c};
  endfunction

  // det3 = e00(e11e22-e12e21) - e01(e10e22-e12e20) + e02(e10e21-e11e20)
  function automatic mac_op_t mac_op(input logic [3:0] s);
    mac_op_t o;
    o = '0;
    unique case (s)
      4'd0: o = '{1'b0, 2'd1, 2'd1, 2'd2, 2'd2, 1'b0, 1'b1, 1'b0};
      4'd1: o = '{1'b0, 2'd1, 2'd2, 2'd2, 2'd1, 1'b0, 1'b0, 1'b1};
      4'd2: o = '{1'b1, 2'd0, 2'd0, 2'd0, 2'd0, 1'b1, 1'b1, 1'b0};
      4'd3: o = '{1'b0, 2'd1, 2'd0, 2'd2, 2'd2, 1'b0, 1'b1, 1'b0};
      4'd4: o = '{1'b0, 2'd1, 2'd2, 2'd2, 2'd0, 1'b0, 1'b0, 1'b1};
      4'd5: o = '{1'b1, 2'd0, 2'd0, 2'd0, 2'd1, 1'b1, 1'b0, 1'b1};
      4'd6: o = '{1'b0, 2'd1, 2'd0, 2'd2, 2'd1, 1'b0, 1'b1, 1'b0};
      4'd7: o = '{1'b0, 2'd1, 2'd1, 2'd2, 2'd0, 1'b0, 1'b0, 1'b1};
      4'd8: o = '{1'b1, 2'd0, 2'd0, 2'd0, 2'd2, 1'b1, 1'b0, 1'b0};
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

// ----- src/matrix4_inverse_adjugate.sv -----
// Top level of the 4x4 fixed-point matrix inverter using the adjugate method.
//
//   Channel   Handshake                   Payload
//   elem      elem_valid / elem_ready     elem   (m4inv_pkg::elem_t)
//   result    result_valid / result_ready result (m4inv_pkg::result_t)
//
// Each element item is written to the store when it is accepted. The item flagged
// last starts the cofactor and determinant work on the shared shift-add
// multiplier, then a restoring division for each result, one quotient bit per
// cycle, which is skipped when the determinant is zero.
// Reset is synchronous and clears the sequencer and the output valid flag only.
// The input side is stalled from the last element until the sixteenth result
// has been loaded into the output register; a stalled result holds the divider.
module matrix4_inverse_adjugate #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              elem_valid,
  output logic              elem_ready,
  input  m4inv_pkg::elem_t  elem,
  output logic              result_valid,
  input  logic              result_ready,
  output m4inv_pkg::result_t result
);
  import m4inv_pkg::*;

  // Exact widths: a 2x2 minor, a 3x3 cofactor, and the 4x4 determinant.
  localparam int MW     = 2 * ELEMENT_WIDTH + 1;
  localparam int CW     = 3 * ELEMENT_WIDTH + 1;
  localparam int W      = 4 * ELEMENT_WIDTH + 2;
  // Dividend is the cofactor magnitude scaled up by 2F fraction bits.
  localparam int NW     = 3 * ELEMENT_WIDTH + 2 * FRACTION_BITS;
  localparam int CNT_W  = $clog2(ELEMENT_WIDTH);
  localparam int DCNT_W = $clog2(NW);
  localparam logic [W-1:0] LIM_NEG = W'(1) << (ELEMENT_WIDTH - 1);
  localparam logic [W-1:0] LIM_POS = LIM_NEG - W'(1);

  state_t state, state_next;

  // Element store: one write port for loads, one registered read port.
  logic [ELEMENT_WIDTH-1:0] store_mem [16];
  logic [ELEMENT_WIDTH-1:0] store_q;
  logic [3:0]               rd_addr;
  logic [ELEMENT_WIDTH-1:0] elem_ext;
  logic [W-1:0]             ev_w;
  logic                     load_wr;

  // Cofactor store, written once per cofactor and read back by the divider.
  logic [CW-1:0] cof_mem [16];
  logic [CW-1:0] cof_q;

  // Sequencer position.
  logic [3:0]        k;
  logic [3:0]        s;
  logic [3:0]        oi;
  logic [CNT_W-1:0]  cnt;
  logic [DCNT_W-1:0] dcnt;
  mac_op_t           op;
  logic              det_step;

  // Multiplier datapath.
  logic [W-1:0]             a_sh;
  logic [ELEMENT_WIDTH-1:0] b_sh;
  logic [W-1:0]             prod;
  logic [W-1:0]             prod_sum;
  logic                     mul_neg;
  logic [MW-1:0]            m;
  logic [CW-1:0]            acc;
  logic [CW-1:0]            cof;
  logic [CW-1:0]            cof_val;
  logic [W-1:0]             det;
  logic [W-1:0]             tgt_val;

  // Determinant results.
  logic [W-1:0] dmag;
  logic         dneg;
  logic         singular;
  logic         dsat;
  logic [31:0]  det_out;
  logic [W-1:0] det_abs;
  logic [W-1:0] dtmp;
  logic         dtneg;
  logic         dtsat;
  logic [W-1:0] dtval;
  logic [W-1:0] dts;

  // Divider datapath.
  logic [NW-1:0]            n_sh;
  logic [W-1:0]             rem;
  logic [W-1:0]             rem2;
  logic                     ge;
  logic [ELEMENT_WIDTH-1:0] q;
  logic                     ovf;
  logic                     cneg;
  logic [CW-1:0]            cmag;

  // Output formatting.
  logic [W-1:0] qw;
  logic         inv_neg;
  logic         isat;
  logic [W-1:0] ival;
  logic [W-1:0] ivs;
  logic         emit;

  assign op       = mac_op(s);
  assign det_step = (s == STEP_DET);

  // Input is sign-extended from 32 bits, or wraps when the element is narrower.
  assign ev_w     = {{(W-32){elem.element_value[31]}}, elem.element_value};
  assign elem_ext = ev_w[ELEMENT_WIDTH-1:0];
  assign load_wr  = (state == ST_LOAD) && elem_valid;

  always_ff @(posedge clk) begin
    if (load_wr) begin
      store_mem[elem.element_index] <= elem_ext;
    end
    store_q <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_COF) begin
      cof_mem[k] <= cof_val;
    end
    cof_q <= cof_mem[{oi[1:0], oi[3:2]}];
  end

  // One shift-add step per cycle; the sign bit of the multiplier has negative
  // weight, and a subtracting step flips every partial product.
  assign mul_neg  = op.sub ^ (cnt == CNT_W'(ELEMENT_WIDTH - 1));
  assign prod_sum = mul_neg ? prod - a_sh : prod + a_sh;

  always_comb begin
    if (det_step) begin
      tgt_val = det;
    end else if (op.to_acc) begin
      tgt_val = {{(W-CW){acc[CW-1]}}, acc};
    end else begin
      tgt_val = {{(W-MW){m[MW-1]}}, m};
    end
  end

  // Cofactor sign follows the checkerboard of (row + column).
  assign cof_val = (k[2] ^ k[0]) ? CW'(-acc) : acc;

  // Determinant: magnitude kept for the divider, output scaled down by 3F.
  assign det_abs = det[W-1] ? -det : det;
  assign dtmp    = det_abs >> (3 * FRACTION_BITS);
  assign dtneg   = det[W-1] && (dtmp != '0);
  assign dtsat   = dtmp > (dtneg ? LIM_NEG : LIM_POS);
  assign dtval   = dtsat ? (dtneg ? LIM_NEG : LIM_POS) : dtmp;
  assign dts     = dtneg ? -dtval : dtval;

  // Restoring division step; quotient bits beyond the element width set ovf.
  assign rem2 = {rem[W-2:0], n_sh[NW-1]};
  assign ge   = rem2 >= dmag;
  assign cmag = cof_q[CW-1] ? CW'(-cof_q) : cof_q;

  assign qw      = {{(W-ELEMENT_WIDTH){1'b0}}, q};
  assign inv_neg = (cneg ^ dneg) && (ovf || (q != '0));
  assign isat    = ovf || (qw > (inv_neg ? LIM_NEG : LIM_POS));
  assign ival    = isat ? (inv_neg ? LIM_NEG : LIM_POS) : qw;
  assign ivs     = inv_neg ? -ival : ival;
  assign emit    = (state == ST_EMIT) && (!result_valid || result_ready);

  // Next state and the store read address.
  always_comb begin
    state_next = state;
    rd_addr    = '0;
    elem_ready = 1'b0;
    unique case (state)
      ST_LOAD: begin
        elem_ready = 1'b1;
        if (elem_valid && elem.last_element) begin
          state_next = ST_RDA;
        end
      end
      ST_RDA: begin
        rd_addr    = minor_addr(k, op.ai, op.aj);
        state_next = ST_RDB;
      end
      ST_RDB: begin
        rd_addr    = det_step ? k : minor_addr(k, op.bi, op.bj);
        state_next = ST_LDB;
      end
      ST_LDB: state_next = ST_MUL;
      ST_MUL: begin
        if (cnt == CNT_W'(ELEMENT_WIDTH - 1)) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        if (s == STEP_LAST) begin
          state_next = ST_COF;
        end else if (det_step && (k == 4'd15)) begin
          state_next = ST_DFIN;
        end else begin
          state_next = ST_RDA;
        end
      end
      ST_COF: begin
        if (k == 4'd15) begin
          state_next = ST_DFIN;
        end else begin
          state_next = ST_RDA;
        end
      end
      ST_DFIN: state_next = ST_DRD;
      ST_DRD:  state_next = ST_DLD;
      ST_DLD: begin
        state_next = singular ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (dcnt == DCNT_W'(NW - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_next = (oi == 4'd15) ? ST_LOAD : ST_DRD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer counters and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      k            <= '0;
      s            <= STEP_FIRST;
      oi           <= '0;
      cnt          <= '0;
      dcnt         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
        oi           <= oi + 4'd1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          k  <= '0;
          s  <= STEP_FIRST;
          oi <= '0;
        end
        ST_LDB:  cnt <= '0;
        ST_MUL:  cnt <= cnt + CNT_W'(1);
        ST_WB: begin
          if (det_step) begin
            k <= k + 4'd1;
            s <= STEP_FIRST;
          end else if (s != STEP_LAST) begin
            s <= s + 4'd1;
          end
        end
        ST_COF: begin
          if (k < 4'd4) begin
            s <= STEP_DET;
          end else begin
            k <= k + 4'd1;
            s <= STEP_FIRST;
          end
        end
        ST_DLD: dcnt <= '0;
        ST_DIV: dcnt <= dcnt + DCNT_W'(1);
        default: ;
      endcase
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_RDB: begin
        if (det_step) begin
          a_sh <= {{(W-CW){cof[CW-1]}}, cof};
        end else if (op.a_from_m) begin
          a_sh <= {{(W-MW){m[MW-1]}}, m};
        end else begin
          a_sh <= {{(W-ELEMENT_WIDTH){store_q[ELEMENT_WIDTH-1]}}, store_q};
        end
      end
      ST_LDB: begin
        b_sh <= store_q;
        if ((det_step && (k == 4'd0)) || (!det_step && op.clr)) begin
          prod <= '0;
        end else begin
          prod <= tgt_val;
        end
      end
      ST_MUL: begin
        if (b_sh[0]) begin
          prod <= prod_sum;
        end
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
      end
      ST_WB: begin
        if (det_step) begin
          det <= prod;
        end else if (op.to_acc) begin
          acc <= prod[CW-1:0];
        end else begin
          m <= prod[MW-1:0];
        end
      end
      ST_COF: cof <= cof_val;
      ST_DFIN: begin
        dmag     <= det_abs;
        dneg     <= det[W-1];
        singular <= (det == '0);
        dsat     <= (det != '0) && dtsat;
        det_out  <= (det == '0) ? 32'd0 : dts[31:0];
      end
      ST_DLD: begin
        cneg <= cof_q[CW-1];
        n_sh <= {cmag[CW-2:0], {(2 * FRACTION_BITS){1'b0}}};
        rem  <= '0;
        q    <= '0;
        ovf  <= 1'b0;
      end
      ST_DIV: begin
        rem  <= ge ? rem2 - dmag : rem2;
        q    <= {q[ELEMENT_WIDTH-2:0], ge};
        ovf  <= ovf | q[ELEMENT_WIDTH-1];
        n_sh <= n_sh << 1;
      end
      default: ;
    endcase
    if (emit) begin
      result.result_index      <= oi;
      result.inverse_value     <= singular ? 32'sd0 : ivs[31:0];
      result.determinant_value <= det_out;
      result.singular          <= singular;
      result.saturated         <= !singular && (isat || dsat);
      result.last_result       <= (oi == 4'd15);
    end
  end

endmodule

// ----- src/m4inv_check.sv -----
// Port-level checker for the matrix inverter, bound to the top level.
`include "assert_macros.svh"

module m4inv_check (
  input logic               clk,
  input logic               rst,
  input logic               elem_valid,
  input logic               elem_ready,
  input m4inv_pkg::elem_t   elem,
  input logic               result_valid,
  input logic               result_ready,
  input m4inv_pkg::result_t result
);

  `M4_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")
  `M4_ASSERT_NEXT(a_busy_after_last, elem_valid && elem_ready && elem.last_element, !elem_ready, "input taken during inversion")
  `M4_ASSERT_NEXT(a_gap_after_run, result_valid && result_ready && result.last_result, !result_valid, "result after the last of a run")
  `M4_ASSERT(a_singular_zero, !(result_valid && result.singular) || (result.inverse_value == 0 && result.determinant_value == 0 && !result.saturated), "singular result not zero")

endmodule

bind matrix4_inverse_adjugate m4inv_check u_m4inv_check (.*);
